[rtl/core/cps_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cps_pkg;

   // Configuration register indices
   localparam int CSR_INDEX_W = 3;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_RADIUS_THR  = 3'd0;
   localparam csr_index_type CSR_DETECT_DIST = 3'd1;
   localparam csr_index_type CSR_BASE_SPEED  = 3'd2;
   localparam csr_index_type CSR_BASE_STEER  = 3'd3;
   localparam csr_index_type CSR_STEER_GAIN  = 3'd4;

   // Result status codes, also the kind of a frame-end snapshot
   typedef enum logic [1:0] {
      STATUS_APPROACH = 2'd0,
      STATUS_STEER    = 2'd1,
      STATUS_END      = 2'd2
   } status_type;

   // Geometry and steering constants
   localparam logic signed [15:0] FORWARD_MIN_MM = -16'sd200;
   localparam logic signed [17:0] LATCH_RESET_MM = 18'sd100000;
   localparam logic signed [5:0]  STEER_LIMIT    = 6'sd26;

   // The steering divisor 512000 is 125 shifted left by 12.
   localparam int                 STEER_DEN        = 512000;
   localparam int                 DEN_SHIFT        = 12;
   localparam logic [22:0]        DEN_ODD          = 23'd125;
   // Whole divisor steps added so that the product is never negative
   localparam int                 STEER_BIAS_STEPS = 16778;
   localparam logic signed [35:0] STEER_BIAS       = 36'(STEER_BIAS_STEPS) * 36'(STEER_DEN);
   // Reciprocal of 125 scaled by two to the 30th, rounded up
   localparam logic [23:0]        RECIP_ODD        = 24'd8589935;
   localparam int                 RECIP_SHIFT      = 30;

   // Configuration held by the top level
   typedef struct packed {
      logic [15:0]        radius_thr;
      logic [14:0]        detect_dist;
      logic [29:0]        detect_sq;
      logic [7:0]         base_speed;
      logic signed [5:0]  base_steer;
      logic [15:0]        steer_gain;
   } cfg_type;

   // Summary of one side after the current item
   typedef struct packed {
      logic               present;
      logic signed [16:0] twice_mean;
   } side_sum_type;

   // Frame-end snapshot passed to the steering arithmetic
   typedef struct packed {
      status_type         kind;
      logic signed [17:0] lat_sum;
   } snap_type;

endpackage

`default_nettype wire

[rtl/core/cps_side.sv]
`timescale 1ns / 1ps
`default_nettype none

module cps_side
   import cps_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic               ins,
   input  wire logic               last,
   input  wire logic signed [15:0] x,
   input  wire logic signed [15:0] y,
   output side_sum_type            sum
);

   logic [1:0]        count_ff;
   logic [1:0]        count_in;
   logic [1:0]        count_upd;
   logic signed [15:0] x_ff [2];
   logic signed [15:0] y_ff [2];
   logic signed [15:0] x_in [2];
   logic signed [15:0] y_in [2];
   logic              lt0;
   logic              lt1;

   // Two-entry insertion keeping the cones of smallest x, earlier first on a tie
   always_comb begin
      lt0       = x < x_ff[0];
      lt1       = x < x_ff[1];
      x_in      = x_ff;
      y_in      = y_ff;
      count_upd = count_ff;
      if (ins) begin
         case (count_ff)
            2'd0: begin
               x_in[0]   = x;
               y_in[0]   = y;
               count_upd = 2'd1;
            end
            2'd1: begin
               if (lt0) begin
                  x_in[1] = x_ff[0];
                  y_in[1] = y_ff[0];
                  x_in[0] = x;
                  y_in[0] = y;
               end else begin
                  x_in[1] = x;
                  y_in[1] = y;
               end
               count_upd = 2'd2;
            end
            default: begin
               if (lt0) begin
                  x_in[1] = x_ff[0];
                  y_in[1] = y_ff[0];
                  x_in[0] = x;
                  y_in[0] = y;
               end else if (lt1) begin
                  x_in[1] = x;
                  y_in[1] = y;
               end
            end
         endcase
      end
      count_in = step ? (last ? 2'd0 : count_upd) : count_ff;
   end

   // Side summary as it stands once this item is included
   always_comb begin
      sum.present = count_upd != 2'd0;
      if (count_upd >= 2'd2) begin
         sum.twice_mean = 17'(y_in[0]) + 17'(y_in[1]);
      end else begin
         sum.twice_mean = {y_in[0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Entry store: no reset, entries above the count are never used
   always_ff @(posedge clock) begin
      if (step) begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
   end

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("side count out of range");

   a_entry_order : assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 |-> x_ff[0] <= x_ff[1])
      else $error("side entries out of order");

endmodule

`default_nettype wire

[rtl/core/cps_track.sv]
`timescale 1ns / 1ps
`default_nettype none

module cps_track
   import cps_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,
   input  wire logic        req_tuser,
   input  wire logic        req_tlast,
   input  wire logic        snap_ready,
   output logic             snap_valid,
   output snap_type         snap
);

   // Input register
   logic               s1_valid_ff;
   logic signed [15:0] s1_x_ff;
   logic signed [15:0] s1_y_ff;
   logic [15:0]        s1_radius_ff;
   logic               s1_has_ff;
   logic               s1_last_ff;

   // Squaring and classification stage
   logic               s2_valid_ff;
   logic signed [15:0] s2_x_ff;
   logic signed [15:0] s2_y_ff;
   logic [30:0]        s2_sqx_ff;
   logic [30:0]        s2_sqy_ff;
   logic               s2_has_ff;
   logic               s2_last_ff;
   logic               s2_cone_r_ff;
   logic               s2_cone_l_ff;

   logic               can1;
   logic               can2;
   logic               step;
   logic signed [31:0] sqx_full;
   logic signed [31:0] sqy_full;
   logic               cone;
   logic [31:0]        dist_sq;
   logic               near;
   logic               far;
   logic signed [17:0] latched_ff;
   logic signed [17:0] latched_in;
   logic               approaching_ff;
   logic               approaching_in;
   side_sum_type       right_sum;
   side_sum_type       left_sum;

   // Stage flow: a stage moves when the one after it is empty or moving
   assign can2       = !s2_valid_ff || snap_ready;
   assign can1       = !s1_valid_ff || can2;
   assign req_tready = can1;
   assign step       = s2_valid_ff && snap_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (can1) begin
            s1_valid_ff <= req_tvalid;
         end
         if (can2) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   // Capture an accepted transaction
   always_ff @(posedge clock) begin
      if (can1 && req_tvalid) begin
         s1_x_ff      <= req_tdata[15:0];
         s1_y_ff      <= req_tdata[31:16];
         s1_radius_ff <= req_tdata[47:32];
         s1_has_ff    <= req_tuser;
         s1_last_ff   <= req_tlast;
      end
   end

   // Squares for the detect range, and the cone test
   assign sqx_full = s1_x_ff * s1_x_ff;
   assign sqy_full = s1_y_ff * s1_y_ff;
   assign cone     = s1_has_ff && (s1_radius_ff > cfg.radius_thr) && (s1_x_ff > FORWARD_MIN_MM);

   always_ff @(posedge clock) begin
      if (can2 && s1_valid_ff) begin
         s2_x_ff      <= s1_x_ff;
         s2_y_ff      <= s1_y_ff;
         s2_sqx_ff    <= sqx_full[30:0];
         s2_sqy_ff    <= sqy_full[30:0];
         s2_has_ff    <= s1_has_ff;
         s2_last_ff   <= s1_last_ff;
         s2_cone_r_ff <= cone && s1_y_ff[15];
         s2_cone_l_ff <= cone && !s1_y_ff[15] && (s1_y_ff != 16'sd0);
      end
   end

   // Nearest two cones on each side
   cps_side u_right (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .ins   (s2_cone_r_ff),
      .last  (s2_last_ff),
      .x     (s2_x_ff),
      .y     (s2_y_ff),
      .sum   (right_sum)
   );

   cps_side u_left (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .ins   (s2_cone_l_ff),
      .last  (s2_last_ff),
      .x     (s2_x_ff),
      .y     (s2_y_ff),
      .sum   (left_sum)
   );

   // Range latch and approach phase
   always_comb begin
      dist_sq        = 32'(s2_sqx_ff) + 32'(s2_sqy_ff);
      near           = s2_has_ff && (dist_sq <= 32'(cfg.detect_sq));
      latched_in     = (step && near) ? 18'(s2_x_ff) : latched_ff;
      far            = latched_in >= $signed({3'b000, cfg.detect_dist});
      approaching_in = approaching_ff;
      if (step && s2_last_ff && approaching_ff && !far) begin
         approaching_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latched_ff     <= LATCH_RESET_MM;
         approaching_ff <= 1'b1;
      end else begin
         latched_ff     <= latched_in;
         approaching_ff <= approaching_in;
      end
   end

   // Frame-end snapshot; the frame that ends the approach gives none
   always_comb begin
      snap_valid   = step && s2_last_ff && !(approaching_ff && !far);
      snap.lat_sum = 18'(right_sum.twice_mean) + 18'(left_sum.twice_mean);
      if (approaching_ff) begin
         snap.kind = STATUS_APPROACH;
      end else if (right_sum.present && left_sum.present) begin
         snap.kind = STATUS_STEER;
      end else begin
         snap.kind = STATUS_END;
      end
   end

   a_approach_once : assert property (@(posedge clock) disable iff (reset)
      !approaching_ff |=> !approaching_ff)
      else $error("approach phase re-entered");

endmodule

`default_nettype wire

[rtl/core/cps_steer.sv]
`timescale 1ns / 1ps
`default_nettype none

module cps_steer
   import cps_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        snap_valid,
   input  wire snap_type    snap,
   output logic             snap_ready,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // steer_cmd[5:0], speed_cmd[13:6], zero fill
   output logic [1:0]       rsp_tuser    // status[1:0]
);

   logic               r1_valid_ff;
   status_type         r1_kind_ff;
   logic signed [17:0] r1_sum_ff;

   logic               r2_valid_ff;
   status_type         r2_kind_ff;
   logic [34:0]        r2_pp_ff;

   logic               r3_valid_ff;
   status_type         r3_kind_ff;
   logic [45:0]        r3_prod_ff;
   logic [22:0]        r3_n_ff;
   logic               r3_lownz_ff;

   logic               rsp_valid_ff;
   logic signed [5:0]  rsp_steer_ff;
   logic [7:0]         rsp_speed_ff;
   status_type         rsp_status_ff;

   logic               out_free;
   logic               r3_can;
   logic               r2_can;
   logic               r1_can;

   logic signed [34:0] gain_prod;
   logic signed [35:0] pp_sum;
   logic [22:0]        n_val;
   logic [46:0]        recip_prod;
   logic [15:0]        kq;
   logic [22:0]        kq_x125;
   logic               rem_nz;
   logic signed [17:0] qb;
   logic signed [17:0] q;
   logic signed [17:0] lim;
   logic signed [5:0]  steer_clamped;
   logic signed [5:0]  steer_in;
   logic [7:0]         speed_in;
   status_type         status_in;

   // Stage flow: each stage moves when the next is empty or moving
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign r3_can     = !r3_valid_ff || out_free;
   assign r2_can     = !r2_valid_ff || r3_can;
   assign r1_can     = !r1_valid_ff || r2_can;
   assign snap_ready = r1_can;

   always_ff @(posedge clock) begin
      if (reset) begin
         r1_valid_ff  <= 1'b0;
         r2_valid_ff  <= 1'b0;
         r3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (r1_can) begin
            r1_valid_ff <= snap_valid;
         end
         if (r2_can) begin
            r2_valid_ff <= r1_valid_ff;
         end
         if (r3_can) begin
            r3_valid_ff <= r2_valid_ff;
         end
         if (out_free) begin
            rsp_valid_ff <= r3_valid_ff;
         end
      end
   end

   // Snapshot register
   always_ff @(posedge clock) begin
      if (r1_can && snap_valid) begin
         r1_kind_ff <= snap.kind;
         r1_sum_ff  <= snap.lat_sum;
      end
   end

   // Gain product, biased by whole divisor steps to stay non-negative
   assign gain_prod = r1_sum_ff * $signed({1'b0, cfg.steer_gain});
   assign pp_sum    = 36'(gain_prod) + STEER_BIAS;

   always_ff @(posedge clock) begin
      if (r2_can && r1_valid_ff) begin
         r2_kind_ff <= r1_kind_ff;
         r2_pp_ff   <= pp_sum[34:0];
      end
   end

   // Drop the power-of-two part of the divisor, then multiply by 1/125
   assign n_val      = r2_pp_ff[34:DEN_SHIFT];
   assign recip_prod = 47'(n_val) * 47'(RECIP_ODD);

   always_ff @(posedge clock) begin
      if (r3_can && r2_valid_ff) begin
         r3_kind_ff  <= r2_kind_ff;
         r3_prod_ff  <= recip_prod[45:0];
         r3_n_ff     <= n_val;
         r3_lownz_ff <= |r2_pp_ff[DEN_SHIFT-1:0];
      end
   end

   // Floor quotient, correction towards zero and clamp
   always_comb begin
      kq      = r3_prod_ff[RECIP_SHIFT +: 16];
      kq_x125 = 23'(kq) * DEN_ODD;
      rem_nz  = r3_lownz_ff || (r3_n_ff != kq_x125);
      qb      = 18'(cfg.base_steer) + 18'(STEER_BIAS_STEPS) - $signed({2'b00, kq});
      q       = (rem_nz && (qb > 18'sd0)) ? qb - 18'sd1 : qb;
      lim     = 18'(STEER_LIMIT);
      if (q > lim) begin
         steer_clamped = STEER_LIMIT;
      end else if (q < -lim) begin
         steer_clamped = -STEER_LIMIT;
      end else begin
         steer_clamped = q[5:0];
      end
   end

   // Result selection by frame-end kind
   always_comb begin
      case (r3_kind_ff)
         STATUS_APPROACH: begin
            steer_in  = cfg.base_steer;
            speed_in  = cfg.base_speed;
            status_in = STATUS_APPROACH;
         end
         STATUS_STEER: begin
            steer_in  = steer_clamped;
            speed_in  = cfg.base_speed;
            status_in = STATUS_STEER;
         end
         default: begin
            steer_in  = 6'sd0;
            speed_in  = 8'd0;
            status_in = STATUS_END;
         end
      endcase
   end

   // Output register
   always_ff @(posedge clock) begin
      if (out_free && r3_valid_ff) begin
         rsp_steer_ff  <= steer_in;
         rsp_speed_ff  <= speed_in;
         rsp_status_ff <= status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_speed_ff, rsp_steer_ff};
   assign rsp_tuser  = rsp_status_ff;

   a_steer_clamped : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == STATUS_STEER) |->
         (rsp_steer_ff <= STEER_LIMIT) && (rsp_steer_ff >= -STEER_LIMIT))
      else $error("steering result outside its limit");

endmodule

`default_nettype wire

[rtl/core/cone_pair_steering_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Cone pair steering unit. Takes one frame of detected circles per run of
// transactions (tlast closes the frame, tuser = 0 marks an item with no circle)
// and gives at most one steering result per frame. The unit accepts one item
// every cycle while req_tready is high; a frame's result follows its last item
// in order through the input register, the squaring stage, the side update,
// the gain multiply, the reciprocal divide and the output register. While the
// result side stalls, the steering stages hold up to four results and the
// intake stages up to two more transactions before req_tready falls, so up to
// six frames can be waiting for their results. Configuration writes take
// effect on the next cycle and must be made while no frame is in flight.
module cone_pair_steering_unit
   import cps_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [47:0]        req_tdata,  // pos_x_mm[15:0], pos_y_mm[31:16], radius_mm[47:32]
   input  wire logic               req_tuser,  // has_circle[0]
   input  wire logic               req_tlast,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [15:0]             rsp_tdata,  // steer_cmd[5:0], speed_cmd[13:6], zero fill
   output logic [1:0]              rsp_tuser,  // status[1:0]
   input  wire logic               csr_wen,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [15:0]        csr_wdata
);

   cfg_type  cfg_ff;
   cfg_type  cfg_in;
   logic     snap_valid;
   logic     snap_ready;
   snap_type snap;

   // Configuration register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_RADIUS_THR: cfg_in.radius_thr = csr_wdata;
            CSR_DETECT_DIST: begin
               cfg_in.detect_dist = csr_wdata[14:0];
               cfg_in.detect_sq   = 30'(csr_wdata[14:0]) * 30'(csr_wdata[14:0]);
            end
            CSR_BASE_SPEED: cfg_in.base_speed = csr_wdata[7:0];
            CSR_BASE_STEER: cfg_in.base_steer = csr_wdata[5:0];
            CSR_STEER_GAIN: cfg_in.steer_gain = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.radius_thr  <= 16'd150;
         cfg_ff.detect_dist <= 15'd1000;
         cfg_ff.detect_sq   <= 30'd1000000;
         cfg_ff.base_speed  <= 8'd0;
         cfg_ff.base_steer  <= 6'sd0;
         cfg_ff.steer_gain  <= 16'd256;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Item intake, cone tracking and range latch
   cps_track u_track (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .snap_ready (snap_ready),
      .snap_valid (snap_valid),
      .snap       (snap)
   );

   // Steering arithmetic and result register
   cps_steer u_steer (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .snap_valid (snap_valid),
      .snap       (snap),
      .snap_ready (snap_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire
